FILE: src/matrix_transform_accumulator_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the transform accumulator core
// Shared forms for the concurrent checks; they sample on clk and are
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH
`define MATRIX_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define MTA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MTA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mta_pkg
// Types, operation codes and helpers shared by the transform accumulator.
// ---------------------------------------------------------------------------
package mta_pkg;

	localparam int MATRIX_ORDER      = 4;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int TRIG_BITS         = 14;
	localparam int ELEM_W            = 32;
	localparam int COEF_W            = 17;

	typedef enum logic [2:0] {
		OP_IDENTITY  = 3'd0,
		OP_ROT_X     = 3'd1,
		OP_ROT_Y     = 3'd2,
		OP_ROT_Z     = 3'd3,
		OP_TRANSLATE = 3'd4,
		OP_READ      = 3'd5
	} op_t;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [MATRIX_ORDER-1:0] col_t;
	typedef col_t [MATRIX_ORDER-1:0]  mat_t;

	// Rotation coefficients: a' = ca*A + sa*B, b' = sb*A + cb*B
	typedef struct packed {
		logic signed [COEF_W-1:0] ca;
		logic signed [COEF_W-1:0] sa;
		logic signed [COEF_W-1:0] sb;
		logic signed [COEF_W-1:0] cb;
	} rot_coef_t;

	// Identity with ones of the given fixed-point format on the diagonal
	function automatic mat_t mta_identity(input int frac);
		mat_t m;
		m = '0;
		for (int i = 0; i < MATRIX_ORDER; i++) begin
			m[i][i] = elem_t'(32'd1 << frac);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: src/mta_rot_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mta_rot_unit
// Rewrites a pair of columns for a rotation: four trig-by-element products per
// row, each rounded to the matrix format, summed in pairs, clamped to 32 bits.
// ---------------------------------------------------------------------------
module mta_rot_unit (
	input  mta_pkg::col_t      col_a,
	input  mta_pkg::col_t      col_b,
	input  mta_pkg::rot_coef_t coef,
	output mta_pkg::col_t      new_a,
	output mta_pkg::col_t      new_b
);
	import mta_pkg::*;

	localparam int PROD_W = COEF_W + ELEM_W;
	localparam int RND_W  = PROD_W - TRIG_BITS;
	localparam int SUM_W  = RND_W + 1;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (TRIG_BITS - 1);
	localparam logic signed [SUM_W-1:0]  MAX_V = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0]  MIN_V = SUM_W'(32'sh8000_0000);

	genvar r;
	generate
		for (r = 0; r < MATRIX_ORDER; r++) begin : g_row
			logic signed [PROD_W-1:0] p_ca, p_sa, p_sb, p_cb;
			logic signed [RND_W-1:0]  q_ca, q_sa, q_sb, q_cb;
			logic signed [SUM_W-1:0]  sum_a, sum_b;

			// Form the four products of this row
			assign p_ca = $signed(coef.ca) * $signed(col_a[r]);
			assign p_sa = $signed(coef.sa) * $signed(col_b[r]);
			assign p_sb = $signed(coef.sb) * $signed(col_a[r]);
			assign p_cb = $signed(coef.cb) * $signed(col_b[r]);

			// Round each product half up to the matrix format
			assign q_ca = RND_W'((p_ca + HALF) >>> TRIG_BITS);
			assign q_sa = RND_W'((p_sa + HALF) >>> TRIG_BITS);
			assign q_sb = RND_W'((p_sb + HALF) >>> TRIG_BITS);
			assign q_cb = RND_W'((p_cb + HALF) >>> TRIG_BITS);

			assign sum_a = SUM_W'(q_ca) + SUM_W'(q_sa);
			assign sum_b = SUM_W'(q_sb) + SUM_W'(q_cb);

			// Clamp to the signed 32-bit range
			assign new_a[r] = (sum_a > MAX_V) ? elem_t'(MAX_V) :
				(sum_a < MIN_V) ? elem_t'(MIN_V) : elem_t'(sum_a);
			assign new_b[r] = (sum_b > MAX_V) ? elem_t'(MAX_V) :
				(sum_b < MIN_V) ? elem_t'(MIN_V) : elem_t'(sum_b);
		end
	endgenerate

endmodule
`default_nettype wire

FILE: src/mta_xlate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mta_xlate_unit
// Computes the new column 3 for a translation: x*M0 + y*M1 + z*M2 + M3,
// each product rounded on its own, the total clamped to 32 bits.
// ---------------------------------------------------------------------------
module mta_xlate_unit #(
	parameter int FRACTION_BITS = mta_pkg::FRACTION_BITS_DEF
) (
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  mta_pkg::mat_t      matrix,
	output mta_pkg::col_t      new_col
);
	import mta_pkg::*;

	localparam int PROD_W = 2 * ELEM_W;
	localparam int RND_W  = PROD_W - FRACTION_BITS;
	localparam int SUM_W  = RND_W + 2;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [SUM_W-1:0]  MAX_V = SUM_W'(32'sh7FFF_FFFF);
	localparam logic signed [SUM_W-1:0]  MIN_V = SUM_W'(32'sh8000_0000);

	genvar r;
	generate
		for (r = 0; r < MATRIX_ORDER; r++) begin : g_row
			logic signed [PROD_W-1:0] p_x, p_y, p_z;
			logic signed [RND_W-1:0]  q_x, q_y, q_z;
			logic signed [SUM_W-1:0]  sum;

			// Form the three products of this row
			assign p_x = $signed(shift_x) * $signed(matrix[0][r]);
			assign p_y = $signed(shift_y) * $signed(matrix[1][r]);
			assign p_z = $signed(shift_z) * $signed(matrix[2][r]);

			// Round each product half up to the matrix format
			assign q_x = RND_W'((p_x + HALF) >>> FRACTION_BITS);
			assign q_y = RND_W'((p_y + HALF) >>> FRACTION_BITS);
			assign q_z = RND_W'((p_z + HALF) >>> FRACTION_BITS);

			assign sum = SUM_W'(q_x) + SUM_W'(q_y) + SUM_W'(q_z)
				+ SUM_W'($signed(matrix[3][r]));

			// Clamp to the signed 32-bit range
			assign new_col[r] = (sum > MAX_V) ? elem_t'(MAX_V) :
				(sum < MIN_V) ? elem_t'(MIN_V) : elem_t'(sum);
		end
	endgenerate

endmodule
`default_nettype wire

FILE: src/matrix_transform_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_transform_accumulator_core
// 4x4 modelview transform accumulator in signed fixed point.
// ---------------------------------------------------------------------------
// Keeps a column-major 4x4 matrix (reset and load-identity give identity) and
// right-multiplies it by rotations about X, Y, Z (sine and cosine in Q2.14)
// or by a translation; a read returns one column. The block takes one
// operation per clock cycle while in_ready is high. An accepted operation
// lands in the input register, and in the following cycle the rotation and
// translation multiplier banks update the matrix register; a read moves
// from the input register to the output register, which delivers its
// column. The combinational matrix update (multiply, round, add, clamp)
// is the loop that sets the clock period. Input ready falls only while a
// read waits in the input register behind an unaccepted result.
// ---------------------------------------------------------------------------
`include "matrix_transform_accumulator_core_macros.svh"

module matrix_transform_accumulator_core #(
	parameter int FRACTION_BITS = mta_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [15:0] sine_value,
	input  logic signed [15:0] cosine_value,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic [1:0]         column_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] row_zero,
	output logic signed [31:0] row_one,
	output logic signed [31:0] row_two,
	output logic signed [31:0] row_three,
	output logic [1:0]         column_number
);
	import mta_pkg::*;

	localparam mat_t IDENTITY = mta_identity(FRACTION_BITS);

	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [15:0] sine_s1;
	logic signed [15:0] cosine_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;
	logic signed [31:0] z_s1;
	logic [1:0]         sel_s1;

	mat_t      matrix_q;
	mat_t      matrix_d;
	logic      out_valid_q;
	col_t      col_q;
	logic [1:0] column_q;

	logic      s1_fire;
	logic      s1_read;
	logic      in_fire;
	col_t      rot_a;
	col_t      rot_b;
	col_t      rot_new_a;
	col_t      rot_new_b;
	col_t      xlate_col;
	rot_coef_t coef;
	logic signed [COEF_W-1:0] sine_w;
	logic signed [COEF_W-1:0] cosine_w;

	// Advance the input stage unless a read is blocked by a waiting result
	assign s1_read  = (op_s1 == OP_READ);
	assign s1_fire  = valid_s1 && (!s1_read || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the operation on each input transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= op;
			sine_s1   <= sine_value;
			cosine_s1 <= cosine_value;
			x_s1      <= shift_x;
			y_s1      <= shift_y;
			z_s1      <= shift_z;
			sel_s1    <= column_select;
		end
	end

	// Pick the column pair and coefficients for the rotation axis
	assign sine_w   = COEF_W'(sine_s1);
	assign cosine_w = COEF_W'(cosine_s1);

	always_comb begin
		rot_a   = (op_s1 == OP_ROT_X) ? matrix_q[1] : matrix_q[0];
		rot_b   = (op_s1 == OP_ROT_Z) ? matrix_q[1] : matrix_q[2];
		coef.ca = cosine_w;
		coef.cb = cosine_w;
		if (op_s1 == OP_ROT_Y) begin
			coef.sa = -sine_w;
			coef.sb = sine_w;
		end else begin
			coef.sa = sine_w;
			coef.sb = -sine_w;
		end
	end

	mta_rot_unit u_rot (
		.col_a (rot_a),
		.col_b (rot_b),
		.coef  (coef),
		.new_a (rot_new_a),
		.new_b (rot_new_b)
	);

	mta_xlate_unit #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_xlate (
		.shift_x (x_s1),
		.shift_y (y_s1),
		.shift_z (z_s1),
		.matrix  (matrix_q),
		.new_col (xlate_col)
	);

	// Select the next matrix for the operation in the input stage
	always_comb begin
		matrix_d = matrix_q;
		case (op_s1)
			OP_IDENTITY: begin
				matrix_d = IDENTITY;
			end
			OP_ROT_X: begin
				matrix_d[1] = rot_new_a;
				matrix_d[2] = rot_new_b;
			end
			OP_ROT_Y: begin
				matrix_d[0] = rot_new_a;
				matrix_d[2] = rot_new_b;
			end
			OP_ROT_Z: begin
				matrix_d[0] = rot_new_a;
				matrix_d[1] = rot_new_b;
			end
			OP_TRANSLATE: begin
				matrix_d[3] = xlate_col;
			end
			default: begin
				matrix_d = matrix_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= IDENTITY;
		end else if (s1_fire) begin
			matrix_q <= matrix_d;
		end
	end

	// Hold a read result until its output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && s1_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_read) begin
			col_q    <= matrix_q[sel_s1];
			column_q <= sel_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign row_zero      = col_q[0];
	assign row_one       = col_q[1];
	assign row_two       = col_q[2];
	assign row_three     = col_q[3];
	assign column_number = column_q;

	// Checks on the stage and matrix control
	`MTA_ASSERT_NEXT(a_read_gives_result, s1_fire && s1_read,
		out_valid && column_number == $past(sel_s1), "read did not produce its column")
	`MTA_ASSERT_NEXT(a_no_spurious_result, !(s1_fire && s1_read) && !out_valid,
		!out_valid, "result appeared without a read")
	`MTA_ASSERT_NEXT(a_matrix_holds, !s1_fire,
		matrix_q == $past(matrix_q), "matrix changed without an operation")
	`MTA_ASSERT_NEXT(a_identity_load, s1_fire && op_s1 == OP_IDENTITY,
		matrix_q == IDENTITY, "identity load failed")
	`MTA_ASSERT_NOW(a_stall_cause, !in_ready,
		valid_s1 && s1_read && out_valid && !out_ready, "input stalled without cause")

endmodule
`default_nettype wire

FILE: verif/matrix_transform_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_transform_checker
// Watches both channels of the transform accumulator, keeps its own copy of
// the 4x4 matrix, predicts every column read and compares it on transfer.
// ---------------------------------------------------------------------------
module matrix_transform_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [15:0] sine_value,
	input  logic signed [15:0] cosine_value,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic [1:0]         column_select,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] row_zero,
	input  logic signed [31:0] row_one,
	input  logic signed [31:0] row_two,
	input  logic signed [31:0] row_three,
	input  logic [1:0]         column_number,
	output int                 fail_count,
	output int                 pending_results
);
	import mta_pkg::*;

	localparam int     MATRIX_FRAC   = FRACTION_BITS_DEF;
	localparam longint ELEM_MAX      = 64'sd2147483647;
	localparam longint ELEM_MIN      = -64'sd2147483648;
	localparam int     PRINT_LIMIT   = 40;

	typedef struct {
		elem_t      r0;
		elem_t      r1;
		elem_t      r2;
		elem_t      r3;
		logic [1:0] col;
	} column_read_t;

	// Shadow matrix, indexed [column][row]
	elem_t        shadow_matrix [MATRIX_ORDER][MATRIX_ORDER];
	column_read_t expected_columns [$];
	int           mismatch_total = 0;

	assign fail_count = mismatch_total;

	// Print one line (up to a limit) and count
	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatch_total < PRINT_LIMIT) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatch_total++;
	endtask

	task automatic compare_field(string name, longint got, longint want);
		if (got != want) begin
			report_mismatch(name, got, want);
		end
	endtask

	// Add half an LSB, then floor-shift to the matrix format
	function automatic longint round_product(longint p, int frac);
		return (p + (longint'(1) << (frac - 1))) >>> frac;
	endfunction

	function automatic elem_t clamp_elem(longint v);
		if (v > ELEM_MAX) begin
			return elem_t'(ELEM_MAX);
		end
		if (v < ELEM_MIN) begin
			return elem_t'(ELEM_MIN);
		end
		return elem_t'(v);
	endfunction

	task automatic load_unit_matrix();
		for (int c = 0; c < MATRIX_ORDER; c++) begin
			for (int r = 0; r < MATRIX_ORDER; r++) begin
				shadow_matrix[c][r] = (c == r) ? elem_t'(longint'(1) << MATRIX_FRAC) : '0;
			end
		end
	endtask

	// Rewrite columns a and b: a' = ca*A + sa*B, b' = sb*A + cb*B
	task automatic rotate_columns(int a, int b, longint ca, longint sa,
			longint sb, longint cb);
		elem_t  new_a [MATRIX_ORDER];
		elem_t  new_b [MATRIX_ORDER];
		longint va;
		longint vb;
		for (int r = 0; r < MATRIX_ORDER; r++) begin
			va       = longint'(shadow_matrix[a][r]);
			vb       = longint'(shadow_matrix[b][r]);
			new_a[r] = clamp_elem(round_product(ca * va, TRIG_BITS) +
				round_product(sa * vb, TRIG_BITS));
			new_b[r] = clamp_elem(round_product(sb * va, TRIG_BITS) +
				round_product(cb * vb, TRIG_BITS));
		end
		for (int r = 0; r < MATRIX_ORDER; r++) begin
			shadow_matrix[a][r] = new_a[r];
			shadow_matrix[b][r] = new_b[r];
		end
	endtask

	// Column 3 becomes x*M0 + y*M1 + z*M2 + M3
	task automatic translate_column(longint x, longint y, longint z);
		longint sum;
		for (int r = 0; r < MATRIX_ORDER; r++) begin
			sum = round_product(x * longint'(shadow_matrix[0][r]), MATRIX_FRAC) +
				round_product(y * longint'(shadow_matrix[1][r]), MATRIX_FRAC) +
				round_product(z * longint'(shadow_matrix[2][r]), MATRIX_FRAC) +
				longint'(shadow_matrix[3][r]);
			shadow_matrix[3][r] = clamp_elem(sum);
		end
	endtask

	// Apply one accepted operation to the shadow matrix
	task automatic predict_operation();
		longint       s;
		longint       c;
		column_read_t col;
		s = longint'(sine_value);
		c = longint'(cosine_value);
		case (op)
			OP_IDENTITY: begin
				load_unit_matrix();
			end
			OP_ROT_X: begin
				rotate_columns(1, 2, c, s, -s, c);
			end
			OP_ROT_Y: begin
				rotate_columns(0, 2, c, -s, s, c);
			end
			OP_ROT_Z: begin
				rotate_columns(0, 1, c, s, -s, c);
			end
			OP_TRANSLATE: begin
				translate_column(longint'(shift_x), longint'(shift_y), longint'(shift_z));
			end
			OP_READ: begin
				col.r0  = shadow_matrix[column_select][0];
				col.r1  = shadow_matrix[column_select][1];
				col.r2  = shadow_matrix[column_select][2];
				col.r3  = shadow_matrix[column_select][3];
				col.col = column_select;
				expected_columns.push_back(col);
			end
			default: begin
				// spare op codes leave the matrix untouched
			end
		endcase
	endtask

	// Compare output transfers first, then predict input transfers
	always @(posedge clk or negedge arst_n) begin
		column_read_t want;
		if (!arst_n) begin
			load_unit_matrix();
			expected_columns.delete();
			pending_results <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_columns.size() == 0) begin
					report_mismatch("column transfer with no read outstanding",
						longint'(column_number), -1);
				end else begin
					want = expected_columns.pop_front();
					compare_field("row_zero", longint'(row_zero), longint'(want.r0));
					compare_field("row_one", longint'(row_one), longint'(want.r1));
					compare_field("row_two", longint'(row_two), longint'(want.r2));
					compare_field("row_three", longint'(row_three), longint'(want.r3));
					compare_field("column_number", longint'(column_number),
						longint'(want.col));
				end
			end
			if (in_valid && in_ready) begin
				predict_operation();
			end
			pending_results <= expected_columns.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the transform accumulator with a directed opening and a long random
// run of rotations, translations, identity loads and column reads, with
// bursty input, a stalling receiver and two long hold-offs.
// ---------------------------------------------------------------------------
module testbench;
	import mta_pkg::*;

	localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
	localparam logic [2:0] OP_SPARE_HIGH = 3'd7;
	localparam int         RANDOM_OPS    = 1550;
	localparam int         DRAIN_CYCLES  = 8;
	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         HOLD_CYCLES   = 300;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [2:0]         op            = '0;
	logic signed [15:0] sine_value    = '0;
	logic signed [15:0] cosine_value  = '0;
	logic signed [31:0] shift_x       = '0;
	logic signed [31:0] shift_y       = '0;
	logic signed [31:0] shift_z       = '0;
	logic [1:0]         column_select = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic signed [31:0] row_zero;
	logic signed [31:0] row_one;
	logic signed [31:0] row_two;
	logic signed [31:0] row_three;
	logic [1:0]         column_number;

	int checker_fails;
	int reads_outstanding;
	int ops_sent    = 0;
	int burst_left  = 0;
	int cycle_count = 0;

	matrix_transform_accumulator_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.sine_value   (sine_value),
		.cosine_value (cosine_value),
		.shift_x      (shift_x),
		.shift_y      (shift_y),
		.shift_z      (shift_z),
		.column_select(column_select),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_zero     (row_zero),
		.row_one      (row_one),
		.row_two      (row_two),
		.row_three    (row_three),
		.column_number(column_number)
	);

	matrix_transform_checker column_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.sine_value     (sine_value),
		.cosine_value   (cosine_value),
		.shift_x        (shift_x),
		.shift_y        (shift_y),
		.shift_z        (shift_z),
		.column_select  (column_select),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.row_zero       (row_zero),
		.row_one        (row_one),
		.row_two        (row_two),
		.row_three      (row_three),
		.column_number  (column_number),
		.fail_count     (checker_fails),
		.pending_results(reads_outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Sine or cosine in Q2.14, leaning on the extremes
	function automatic logic signed [15:0] pick_trig();
		int v;
		case ($urandom_range(0, 9))
			0: v = 16384;
			1: v = -16384;
			2: v = 0;
			3, 4: v = int'($urandom_range(0, 8192)) - 4096;
			default: v = int'($urandom_range(0, 32768)) - 16384;
		endcase
		return 16'(v);
	endfunction

	// Translation in Q16.16: modest or full range, some extremes
	function automatic logic signed [31:0] pick_shift();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4, 5: return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
			default: return 32'($urandom);
		endcase
	endfunction

	// Offer one operation; end a burst with a gap, then hold until transfer
	task automatic send_op(logic [2:0] code, logic signed [15:0] s,
			logic signed [15:0] c, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [1:0] sel);
		int gap;
		if (burst_left == 0) begin
			gap      = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		op            <= code;
		sine_value    <= s;
		cosine_value  <= c;
		shift_x       <= x;
		shift_y       <= y;
		shift_z       <= z;
		column_select <= sel;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		ops_sent++;
	endtask

	// Receiver: stall pattern picked at random from four modes; two long hold-offs
	initial begin : result_sink
		int hold_left;
		int mode;
		int phase;
		bit first_hold_done;
		bit second_hold_done;
		hold_left        = 0;
		mode             = 0;
		phase            = 0;
		first_hold_done  = 1'b0;
		second_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (phase % 64 == 0) begin
				mode = $urandom_range(0, 3);
			end
			if (hold_left == 0 && !first_hold_done && ops_sent >= 400) begin
				first_hold_done = 1'b1;
				hold_left       = HOLD_CYCLES;
			end else if (hold_left == 0 && !second_hold_done && ops_sent >= 1100) begin
				second_hold_done = 1'b1;
				hold_left        = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (phase % 7 < 3);
				endcase
			end
		end
	end

	// Cycle limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		int         pick;
		logic [2:0] code;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Columns of the reset identity
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd1);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd2);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd3);
		// Quarter turn, then coefficient pairs of norm above one
		send_op(OP_ROT_X, 16'sd16384, 16'sd0, 0, 0, 0, 2'd1);
		send_op(OP_ROT_Y, -16'sd16384, 16'sd16384, 0, 0, 0, 2'd2);
		send_op(OP_ROT_Z, 16'sd16384, -16'sd16384, 0, 0, 0, 2'd3);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd2);
		// Translation extremes drive column 3 into saturation
		send_op(OP_TRANSLATE, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh12345678, 2'd3);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd3);
		send_op(OP_TRANSLATE, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd3);
		// Spare op codes with every field high leave the matrix alone
		send_op(OP_SPARE_LOW, -16'sd1, -16'sd1, -32'sd1, -32'sd1, -32'sd1, 2'd3);
		send_op(OP_SPARE_HIGH, -16'sd1, -16'sd1, -32'sd1, -32'sd1, -32'sd1, 2'd3);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd1);
		// Identity, then a half-unit translation and a zeroing rotation
		send_op(OP_IDENTITY, 16'sd16384, 16'sd16384, -32'sd1, -32'sd1, -32'sd1, 2'd2);
		send_op(OP_TRANSLATE, 0, 0, 32'sh0000_8000, -32'sh0000_8000, 32'sh0001_8000, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd3);
		send_op(OP_ROT_X, 16'sd0, 16'sd0, 0, 0, 0, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd1);
		send_op(OP_ROT_Z, -16'sd16384, -16'sd16384, 0, 0, 0, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd0);
		send_op(OP_IDENTITY, 0, 0, 0, 0, 0, 2'd0);
		send_op(OP_READ, 0, 0, 0, 0, 0, 2'd0);

		// Random run: identity now and then keeps the matrix in range
		for (int k = 0; k < RANDOM_OPS; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				code = OP_IDENTITY;
			end else if (pick < 46) begin
				case (pick % 3)
					0: code = OP_ROT_X;
					1: code = OP_ROT_Y;
					default: code = OP_ROT_Z;
				endcase
			end else if (pick < 66) begin
				code = OP_TRANSLATE;
			end else if (pick < 96) begin
				code = OP_READ;
			end else begin
				code = (pick % 2 == 0) ? OP_SPARE_LOW : OP_SPARE_HIGH;
			end
			send_op(code, pick_trig(), pick_trig(), pick_shift(), pick_shift(),
				pick_shift(), 2'($urandom_range(0, 3)));
		end
		in_valid <= 1'b0;

		// Drain outstanding reads, then let the pipeline settle
		@(posedge clk);
		while (reads_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (checker_fails == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
